// ===== src/c5mp_pkg.sv =====
// Package with the shared types and fixed widths of the convolution and pooling layer.
`default_nettype none
package c5mp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FILT_W   = 4;
   localparam int TAP_W    = 5;
   localparam int COORD_W  = 4;
   localparam int OUT_W    = 36;

   typedef enum logic [0:0] {
      OP_WEIGHT = 1'b0,
      OP_PIXEL  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LB_RD,
      S_LB_WR,
      S_LB_PUT,
      S_MAC,
      S_DRAIN,
      S_POOL
   } state_type;

endpackage
`default_nettype wire

// ===== src/c5mp_req_if.sv =====
// Request channel interface that carries weight loads and image pixels.
`default_nettype none
interface c5mp_req_if import c5mp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   op_type                     op;
   logic [FILT_W-1:0]          filter_index;
   logic [TAP_W-1:0]           tap_index;
   logic signed [SAMPLE_W-1:0] value;
   logic                       image_start;

   modport source (output valid, op, filter_index, tap_index, value, image_start,
                   input ready);
   modport sink (input valid, op, filter_index, tap_index, value, image_start,
                 output ready);
endinterface
`default_nettype wire

// ===== src/c5mp_rsp_if.sv =====
// Response channel interface that carries the pooled results.
`default_nettype none
interface c5mp_rsp_if import c5mp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FILT_W-1:0]       out_filter;
   logic [COORD_W-1:0]      pool_x;
   logic [COORD_W-1:0]      pool_y;
   logic signed [OUT_W-1:0] pooled_value;
   logic                    last;

   modport source (output valid, out_filter, pool_x, pool_y, pooled_value, last,
                   input ready);
   modport sink (input valid, out_filter, pool_x, pool_y, pooled_value, last,
                 output ready);
endinterface
`default_nettype wire

// ===== src/conv5x5_maxpool2x2_layer.sv =====
// Top level of the 5x5 valid convolution layer with a 2x2 max pool.
//
// Items arrive on the req channel. An op of weight writes one filter tap into
// the weight memory; taps out of range are dropped. An op of pixel feeds one
// image pixel in raster order; image_start clears the position. Each pixel
// refreshes the window from the line buffer memory through its one read port,
// one buffered row at a time, a read state and then a write state per row.
// When the window is full and inside a pool cell, one shared 16x16
// multiply-accumulate unit walks all taps of every filter. On the fourth value
// of a pool cell one result per filter leaves on the rsp channel through an
// output register, the last filter flagged. The block accepts no item while
// it works on a pixel. If the receiver stalls, the sequencer waits on the
// output register before it emits the next result. Reset clears the sequencer,
// position counters, window and output valid; the memories hold no reset
// value and need no clearing pass.
`default_nettype none
module conv5x5_maxpool2x2_layer import c5mp_pkg::*; #(
   parameter int IMAGE_SIZE  = 28,
   parameter int KERNEL_SIZE = 5,
   parameter int NUM_FILTERS = 10
) (
   input wire logic    clock,
   input wire logic    reset,
   c5mp_req_if.sink    req,
   c5mp_rsp_if.source  rsp
);

   localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LB_ROWS   = KERNEL_SIZE - 1;
   localparam int CONV_SIZE = IMAGE_SIZE - KERNEL_SIZE + 1;
   localparam int POOL_SIZE = CONV_SIZE / 2;
   localparam int POOL_ROWS = POOL_SIZE > 1 ? POOL_SIZE : 1;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = PROD_W + $clog2(TAPS);
   localparam int CW        = $clog2(IMAGE_SIZE);
   localparam int TW        = $clog2(TAPS);
   localparam int LW        = LB_ROWS > 1 ? $clog2(LB_ROWS) : 1;
   localparam int FW        = NUM_FILTERS > 1 ? $clog2(NUM_FILTERS) : 1;
   localparam int W_DEPTH   = NUM_FILTERS * TAPS;
   localparam int L_DEPTH   = LB_ROWS * IMAGE_SIZE;
   localparam int P_DEPTH   = POOL_ROWS * NUM_FILTERS;
   localparam int WAW       = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
   localparam int LAW       = L_DEPTH > 1 ? $clog2(L_DEPTH) : 1;
   localparam int PAW       = P_DEPTH > 1 ? $clog2(P_DEPTH) : 1;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             col_ff, col_in, row_ff, row_in;
   logic [LW-1:0]             rb_ff, rb_in, slot_ff, slot_in, ky_ff, ky_in;
   logic signed [SAMPLE_W-1:0] pix_ff, pix_in;
   logic signed [SAMPLE_W-1:0] win_ff [TAPS];
   logic signed [SAMPLE_W-1:0] win_in [TAPS];
   logic [TW-1:0]             tap_ff, tap_in;
   logic [FW-1:0]             filt_ff, filt_in;
   logic                      drain_ff, drain_in, iss_ff, iss_in, pv_ff, pv_in;
   logic signed [SAMPLE_W-1:0] wv_ff, wv_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [CW-1:0]             px_ff, px_in, py_ff, py_in;
   logic                      first_ff, first_in, final_ff, final_in;
   logic                      rv_ff, rv_in, rlast_ff, rlast_in;
   logic [FILT_W-1:0]         rfilt_ff, rfilt_in;
   logic [COORD_W-1:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic signed [OUT_W-1:0]   rval_ff, rval_in;

   logic                      w_we, w_re, l_we, l_re, p_we, p_re;
   logic [WAW-1:0]            w_waddr, w_raddr;
   logic [LAW-1:0]            l_waddr, l_raddr;
   logic [PAW-1:0]            p_addr;
   logic [SAMPLE_W-1:0]       w_rdata, l_rdata;
   logic [ACC_W-1:0]          p_rdata;
   logic signed [ACC_W-1:0]   pool_new;
   logic [CW-1:0]             cx, cy;
   logic                      conv_ok;

   c5mp_ram #(.WIDTH(SAMPLE_W), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(req.value),
      .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
   );

   c5mp_ram #(.WIDTH(SAMPLE_W), .DEPTH(L_DEPTH)) u_line_ram (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(pix_ff),
      .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
   );

   c5mp_ram #(.WIDTH(ACC_W), .DEPTH(P_DEPTH)) u_pool_ram (
      .clock(clock), .we(p_we), .waddr(p_addr), .wdata(pool_new),
      .re(p_re), .raddr(p_addr), .rdata(p_rdata)
   );

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rv_ff;
   assign rsp.out_filter   = rfilt_ff;
   assign rsp.pool_x       = rx_ff;
   assign rsp.pool_y       = ry_ff;
   assign rsp.pooled_value = rval_ff;
   assign rsp.last         = rlast_ff;

   assign w_waddr  = WAW'(int'(req.filter_index) * TAPS + int'(req.tap_index));
   assign w_raddr  = WAW'(int'(filt_ff) * TAPS + int'(tap_ff));
   assign l_waddr  = LAW'(int'(rb_ff) * IMAGE_SIZE + int'(col_ff));
   assign l_raddr  = LAW'(int'(slot_ff) * IMAGE_SIZE + int'(col_ff));
   assign p_addr   = PAW'(int'(px_ff) * NUM_FILTERS + int'(filt_ff));
   assign cx       = col_ff - CW'(KERNEL_SIZE - 1);
   assign cy       = row_ff - CW'(KERNEL_SIZE - 1);
   assign conv_ok  = (int'(col_ff) >= KERNEL_SIZE - 1) && (int'(row_ff) >= KERNEL_SIZE - 1)
                     && (int'(cx >> 1) < POOL_SIZE) && (int'(cy >> 1) < POOL_SIZE);
   assign pool_new = (first_ff || acc_ff > signed'(p_rdata)) ? acc_ff : signed'(p_rdata);

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      rb_in    = rb_ff;
      slot_in  = slot_ff;
      ky_in    = ky_ff;
      pix_in   = pix_ff;
      win_in   = win_ff;
      tap_in   = tap_ff;
      filt_in  = filt_ff;
      drain_in = drain_ff;
      iss_in   = 1'b0;
      pv_in    = iss_ff;
      wv_in    = wv_ff;
      prod_in  = signed'(w_rdata) * wv_ff;
      acc_in   = pv_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      first_in = first_ff;
      final_in = final_ff;
      rv_in    = rv_ff && !rsp.ready;
      rlast_in = rlast_ff;
      rfilt_in = rfilt_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rval_in  = rval_ff;
      w_we     = 1'b0;
      w_re     = 1'b0;
      l_we     = 1'b0;
      l_re     = 1'b0;
      p_we     = 1'b0;
      p_re     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.op == OP_WEIGHT) begin
                  w_we = (int'(req.filter_index) < NUM_FILTERS)
                         && (int'(req.tap_index) < TAPS);
               end else begin
                  pix_in = req.value;
                  for (int i = 0; i < TAPS; i++) begin
                     if (i % KERNEL_SIZE != KERNEL_SIZE - 1) begin
                        win_in[i] = win_ff[i + 1];
                     end
                  end
                  ky_in = '0;
                  if (req.image_start) begin
                     col_in  = '0;
                     row_in  = '0;
                     rb_in   = '0;
                     slot_in = '0;
                  end else begin
                     slot_in = rb_ff;
                  end
                  state_in = S_LB_RD;
               end
            end
         end
         S_LB_RD: begin
            l_re     = 1'b1;
            state_in = S_LB_WR;
         end
         S_LB_WR: begin
            win_in[TW'(int'(ky_ff) * KERNEL_SIZE + KERNEL_SIZE - 1)] = l_rdata;
            slot_in = (int'(slot_ff) == LB_ROWS - 1) ? '0 : slot_ff + 1'b1;
            if (int'(ky_ff) == LB_ROWS - 1) begin
               state_in = S_LB_PUT;
            end else begin
               ky_in    = ky_ff + 1'b1;
               state_in = S_LB_RD;
            end
         end
         S_LB_PUT: begin
            win_in[TAPS - 1] = pix_ff;
            l_we     = 1'b1;
            px_in    = cx >> 1;
            py_in    = cy >> 1;
            first_in = !cx[0] && !cy[0];
            final_in = cx[0] && cy[0];
            if (int'(col_ff) == IMAGE_SIZE - 1) begin
               col_in = '0;
               if (int'(row_ff) == IMAGE_SIZE - 1) begin
                  row_in = '0;
                  rb_in  = '0;
               end else begin
                  row_in = row_ff + 1'b1;
                  rb_in  = (int'(rb_ff) == LB_ROWS - 1) ? '0 : rb_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
            filt_in  = '0;
            tap_in   = '0;
            acc_in   = '0;
            state_in = conv_ok ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            w_re   = 1'b1;
            wv_in  = win_ff[tap_ff];
            iss_in = 1'b1;
            p_re   = (tap_ff == '0);
            if (int'(tap_ff) == TAPS - 1) begin
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_POOL;
            end
         end
         S_POOL: begin
            if (!final_ff || !rv_ff || rsp.ready) begin
               p_we = 1'b1;
               if (final_ff) begin
                  rv_in    = 1'b1;
                  rfilt_in = FILT_W'(filt_ff);
                  rx_in    = COORD_W'(px_ff);
                  ry_in    = COORD_W'(py_ff);
                  rval_in  = OUT_W'(pool_new);
                  rlast_in = (int'(filt_ff) == NUM_FILTERS - 1);
               end
               tap_in = '0;
               acc_in = '0;
               if (int'(filt_ff) == NUM_FILTERS - 1) begin
                  state_in = S_IDLE;
               end else begin
                  filt_in  = filt_ff + 1'b1;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         rb_ff    <= '0;
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
         iss_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         rb_ff    <= rb_in;
         win_ff   <= win_in;
         iss_ff   <= iss_in;
         pv_ff    <= pv_in;
         rv_ff    <= rv_in;
      end
      slot_ff  <= slot_in;
      ky_ff    <= ky_in;
      pix_ff   <= pix_in;
      tap_ff   <= tap_in;
      filt_ff  <= filt_in;
      drain_ff <= drain_in;
      wv_ff    <= wv_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      first_ff <= first_in;
      final_ff <= final_in;
      rlast_ff <= rlast_in;
      rfilt_ff <= rfilt_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rval_ff  <= rval_in;
   end

endmodule
`default_nettype wire

// ===== src/c5mp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module c5mp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic                                    re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== verif/conv5x5_maxpool2x2_layer_tb.sv =====
// Testbench that checks the convolution and max pool layer against a built-in predictor.
`timescale 1ns / 1ps
module conv5x5_maxpool2x2_layer_tb;
   import c5mp_pkg::*;

   localparam int IMG      = 28;
   localparam int KSZ      = 5;
   localparam int NFILT    = 10;
   localparam int TAPS     = KSZ * KSZ;
   localparam int PSZ      = (IMG - KSZ + 1) / 2;
   localparam int QUIET_MAX = 20000;

   typedef struct packed {
      logic [FILT_W-1:0]  filt;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [OUT_W-1:0]   val;
      logic               last;
   } pooled_type;

   class pool_scoreboard;
      pooled_type pending[$];
      int      weights[NFILT][TAPS];
      int      lines[KSZ-1][IMG];
      int      win[KSZ][KSZ];
      int      col;
      int      row;
      longint  cell_max[PSZ][NFILT];
      int      errors;

      // Advances the layer state by one accepted transfer and queues its pooled results.
      function void note(op_type op, logic [FILT_W-1:0] fi, logic [TAP_W-1:0] ti,
                         logic signed [SAMPLE_W-1:0] v, logic st);
         int      c, r, cx, cy, px, py;
         longint  acc;
         bit      first_v, final_v;
         pooled_type e;
         if (op == OP_WEIGHT) begin
            if (fi < NFILT && ti < TAPS) weights[fi][ti] = int'(v);
            return;
         end
         if (st) begin
            col = 0;
            row = 0;
         end
         c = col;
         r = row;
         for (int ky = 0; ky < KSZ; ky++)
            for (int kx = 0; kx + 1 < KSZ; kx++) win[ky][kx] = win[ky][kx+1];
         for (int ky = 0; ky < KSZ - 1; ky++) win[ky][KSZ-1] = lines[(r + ky) % (KSZ-1)][c];
         win[KSZ-1][KSZ-1] = int'(v);
         lines[r % (KSZ-1)][c] = int'(v);
         col = c + 1;
         row = r;
         if (col >= IMG) begin
            col = 0;
            row = (r + 1 >= IMG) ? 0 : r + 1;
         end
         if (c < KSZ - 1 || r < KSZ - 1) return;
         cx = c - (KSZ - 1);
         cy = r - (KSZ - 1);
         px = cx / 2;
         py = cy / 2;
         if (px >= PSZ || py >= PSZ) return;
         first_v = (cx % 2 == 0) && (cy % 2 == 0);
         final_v = (cx % 2 == 1) && (cy % 2 == 1);
         for (int f = 0; f < NFILT; f++) begin
            acc = 0;
            for (int ky = 0; ky < KSZ; ky++)
               for (int kx = 0; kx < KSZ; kx++)
                  acc += longint'(weights[f][ky*KSZ+kx]) * longint'(win[ky][kx]);
            if (first_v || acc > cell_max[px][f]) cell_max[px][f] = acc;
         end
         if (final_v) begin
            for (int f = 0; f < NFILT; f++) begin
               e.filt = FILT_W'(f);
               e.px   = COORD_W'(px);
               e.py   = COORD_W'(py);
               e.val  = OUT_W'(cell_max[px][f]);
               e.last = (f == NFILT - 1);
               pending.push_back(e);
            end
         end
      endfunction

      function void check(pooled_type got);
         pooled_type e;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected: filter %0d x %0d y %0d value %0d",
                     $time, got.filt, got.px, got.py, $signed(got.val));
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            $display("%0t: mismatch: expected f %0d x %0d y %0d v %0d last %0b",
                     $time, e.filt, e.px, e.py, $signed(e.val), e.last);
            $display("%0t:           actual f %0d x %0d y %0d v %0d last %0b",
                     $time, got.filt, got.px, got.py, $signed(got.val), got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_go;
   bit   holding;
   int   quiet;
   pool_scoreboard sb;

   c5mp_req_if req_ch ();
   c5mp_rsp_if rsp_ch ();

   conv5x5_maxpool2x2_layer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sd32767;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send(op_type op, logic [FILT_W-1:0] fi, logic [TAP_W-1:0] ti,
                       logic signed [SAMPLE_W-1:0] v, logic st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.op           = op;
      req_ch.filter_index = fi;
      req_ch.tap_index    = ti;
      req_ch.value        = v;
      req_ch.image_start  = st;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(op, fi, ti, v, st);
      @(negedge clock);
   endtask

   task automatic pixel_sweep(int count, bit start);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(39) == 0)
            send(OP_WEIGHT, FILT_W'($urandom), TAP_W'($urandom), rand_sample(),
                 1'($urandom));
         send(OP_PIXEL, FILT_W'($urandom), TAP_W'($urandom), rand_sample(),
              start && (i == 0));
      end
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || holding) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      pooled_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.filt = rsp_ch.out_filter;
         got.px   = rsp_ch.pool_x;
         got.py   = rsp_ch.pool_y;
         got.val  = rsp_ch.pooled_value;
         got.last = rsp_ch.last;
         sb.check(got);
      end
   end

   initial begin
      holding = 1'b0;
      wait (hold_go);
      wait (rsp_ch.valid);
      @(negedge clock);
      holding = 1'b1;
      repeat (3000) @(negedge clock);
      holding = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      sb = new();
      send_idle_pct  = 11;
      recv_stall_pct = 66;
      hold_go        = 1'b0;
      quiet          = 0;
      reset          = 1'b1;
      rsp_ch.ready   = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_WEIGHT;
      req_ch.filter_index = '0;
      req_ch.tap_index    = '0;
      req_ch.value        = '0;
      req_ch.image_start  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Filter 0 gets the largest weights and filter 1 the most negative ones.
      for (int f = 0; f < NFILT; f++)
         for (int t = 0; t < TAPS; t++)
            send(OP_WEIGHT, FILT_W'(f), TAP_W'(t), (f == 0) ? 16'sd32767 :
                 (f == 1) ? 16'sh8000 : rand_sample(), f == 2);
      send(OP_WEIGHT, 4'd15, 5'd31, 16'sd1, 1'b1);
      send(OP_WEIGHT, 4'd10, 5'd0, -16'sd1, 1'b0);
      send(OP_WEIGHT, 4'd0, 5'd25, 16'sd0, 1'b0);

      // The receiver holds off once the first results of the image appear.
      hold_go = 1'b1;
      for (int i = 0; i < 6 * IMG; i++)
         send(OP_PIXEL, 4'd0, 5'd0, (i < 3 * IMG) ? 16'sh8000 : 16'sd32767, i == 0);
      wait_drained();

      send_idle_pct  = 66;
      recv_stall_pct = 11;
      pixel_sweep(2 * IMG, 1'b0);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pixel_sweep(2 * IMG, 1'b0);
      wait_drained();
      repeat (600) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
